/* rtl/touch_frame_deframer_macros.svh */
// Assertion macros shared by the touch frame deframer RTL.
`ifndef TOUCH_FRAME_DEFRAMER_MACROS_SVH
`define TOUCH_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTH

`define TFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("touch_frame_deframer: property violated");

`define TFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("touch_frame_deframer: implication violated");

`else

`define TFD_ASSERT(lbl, clk, rst_n, prop)

`define TFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tfd_pkg.sv */
// Constants and types of the touch frame deframer.
package tfd_pkg;

  localparam int SlotCount   = 10;
  localparam int HeaderBytes = 10;
  localparam int FrameBytes  = HeaderBytes + 4 * SlotCount;
  localparam int PosW        = $clog2(FrameBytes);
  localparam int SlotW       = 4;

  localparam logic [7:0] MagicR  = 8'h52;
  localparam logic [7:0] MagicT  = 8'h54;
  localparam logic [7:0] Version = 8'h01;

  localparam logic [PosW-1:0] PosMagicR   = PosW'(0);
  localparam logic [PosW-1:0] PosMagicT   = PosW'(1);
  localparam logic [PosW-1:0] PosVersion  = PosW'(2);
  localparam logic [PosW-1:0] PosSpare    = PosW'(3);
  localparam logic [PosW-1:0] PosSeqLo    = PosW'(4);
  localparam logic [PosW-1:0] PosSeqHi    = PosW'(5);
  localparam logic [PosW-1:0] PosWidthLo  = PosW'(6);
  localparam logic [PosW-1:0] PosWidthHi  = PosW'(7);
  localparam logic [PosW-1:0] PosHeightLo = PosW'(8);
  localparam logic [PosW-1:0] PosHeightHi = PosW'(9);
  localparam logic [PosW-1:0] PosHeader   = PosW'(HeaderBytes);
  localparam logic [PosW-1:0] PosLast     = PosW'(FrameBytes - 1);

  localparam logic [1:0] LaneXLo = 2'd0;
  localparam logic [1:0] LaneXHi = 2'd1;
  localparam logic [1:0] LaneYLo = 2'd2;
  localparam logic [1:0] LaneYHi = 2'd3;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(SlotCount - 1);

  typedef struct packed {
    logic [15:0]        frame_seq;
    logic [15:0]        frame_width;
    logic [15:0]        frame_height;
    logic [SlotW-1:0]   slot_index;
    logic signed [15:0] touch_x;
    logic signed [15:0] touch_y;
    logic               last_slot;
  } result_t;

endpackage

/* rtl/tfd_parser.sv */
// Frame parser: byte position, header checks, sequence history and slot assembly.
`include "touch_frame_deframer_macros.svh"

module tfd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 new_conn_i,
  output logic                 res_valid_o,
  output tfd_pkg::result_t     res_o
);

  logic [tfd_pkg::PosW-1:0] pos_q, pos_d, pos;
  logic                     ok_q, ok_d;
  logic                     hist_ok_q, hist_ok_d, hist_ok;
  logic [15:0]              hist_seq_q, hist_seq_d, hist_seq;
  logic [15:0]              width_q, width_d;
  logic [15:0]              height_q, height_d;
  logic [15:0]              x_q, x_d;
  logic [7:0]               low_q, low_d;
  logic [15:0]              word;
  logic [15:0]              seq_diff;
  logic                     seq_newer;
  logic [tfd_pkg::PosW-1:0] rel;
  logic [tfd_pkg::SlotW-1:0] slot;

  always_comb begin
    pos      = new_conn_i ? '0 : pos_q;
    hist_ok  = new_conn_i ? 1'b0 : hist_ok_q;
    hist_seq = new_conn_i ? 16'h0000 : hist_seq_q;
    word     = {data_byte_i, low_q};
    seq_diff = word - hist_seq;
    seq_newer = (seq_diff != 16'h0000) && !seq_diff[15];
    rel      = pos - tfd_pkg::PosHeader;
    slot     = tfd_pkg::SlotW'(rel >> 2);

    pos_d      = (pos == tfd_pkg::PosLast) ? '0 : pos + 1'b1;
    ok_d       = ok_q;
    hist_ok_d  = hist_ok;
    hist_seq_d = hist_seq;
    width_d    = width_q;
    height_d   = height_q;
    x_d        = x_q;
    low_d      = low_q;
    res_valid_o = 1'b0;

    case (pos)
      tfd_pkg::PosMagicR: ok_d = (data_byte_i == tfd_pkg::MagicR);
      tfd_pkg::PosMagicT: ok_d = ok_q && (data_byte_i == tfd_pkg::MagicT);
      tfd_pkg::PosVersion: ok_d = ok_q && (data_byte_i == tfd_pkg::Version);
      tfd_pkg::PosSpare: ;
      tfd_pkg::PosSeqLo, tfd_pkg::PosWidthLo, tfd_pkg::PosHeightLo: low_d = data_byte_i;
      tfd_pkg::PosSeqHi: begin
        if (ok_q && (!hist_ok || seq_newer)) begin
          hist_ok_d  = 1'b1;
          hist_seq_d = word;
        end else begin
          ok_d = 1'b0;
        end
      end
      tfd_pkg::PosWidthHi: width_d = word;
      tfd_pkg::PosHeightHi: height_d = word;
      default: begin
        case (rel[1:0])
          tfd_pkg::LaneXLo, tfd_pkg::LaneYLo: low_d = data_byte_i;
          tfd_pkg::LaneXHi: x_d = word;
          tfd_pkg::LaneYHi: res_valid_o = take_i && ok_q;
          default: ;
        endcase
      end
    endcase

    res_o.frame_seq    = hist_seq;
    res_o.frame_width  = width_q;
    res_o.frame_height = height_q;
    res_o.slot_index   = slot;
    res_o.touch_x      = x_q;
    res_o.touch_y      = word;
    res_o.last_slot    = (slot == tfd_pkg::LastSlot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ok_q       <= 1'b0;
      hist_ok_q  <= 1'b0;
      hist_seq_q <= 16'h0000;
      width_q    <= 16'h0000;
      height_q   <= 16'h0000;
      x_q        <= 16'h0000;
      low_q      <= 8'h00;
    end else if (take_i) begin
      pos_q      <= pos_d;
      ok_q       <= ok_d;
      hist_ok_q  <= hist_ok_d;
      hist_seq_q <= hist_seq_d;
      width_q    <= width_d;
      height_q   <= height_d;
      x_q        <= x_d;
      low_q      <= low_d;
    end
  end

  `TFD_ASSERT(a_pos_in_frame, clk_i, rst_ni, pos_q <= tfd_pkg::PosLast)
  `TFD_ASSERT_IMP(a_result_has_history, clk_i, rst_ni, res_valid_o, hist_ok_q && !new_conn_i)
  `TFD_ASSERT_IMP(a_result_in_slots, clk_i, rst_ni, res_valid_o, pos_q >= tfd_pkg::PosHeader)

endmodule

/* rtl/touch_frame_deframer.sv */
// Top level of the touch frame deframer: stream ports and result register.
//
// The block takes one byte per request on the slave stream (tuser marks the first byte
// of a new connection) and splits the stream into fixed 50-byte touch frames. A frame
// with a wrong magic or version, or whose sequence number is not newer than the last
// accepted one, is consumed silently. For accepted frames one result leaves on the
// master stream for every touch slot, in the cycle after the slot's fourth byte is taken,
// with tlast set on the final slot. The result register decouples the two sides so a
// byte is taken in every cycle in which the result register is empty or being drained.
`include "touch_frame_deframer_macros.svh"

module touch_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] new_connection
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] frame_seq, [31:16] frame_width, [47:32] frame_height, [51:48] slot_index,
  // [67:52] touch_x, [83:68] touch_y, [87:84] zero
  output logic [87:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // last_slot
);

  logic             s_accept;
  logic             res_valid;
  tfd_pkg::result_t res;
  logic             m_valid_q;
  tfd_pkg::result_t m_res_q;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  tfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (s_accept),
    .data_byte_i (s_axis_tdata_i),
    .new_conn_i  (s_axis_tuser_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, m_res_q.touch_y, m_res_q.touch_x, m_res_q.slot_index,
                            m_res_q.frame_height, m_res_q.frame_width, m_res_q.frame_seq};
  assign m_axis_tlast_o  = m_res_q.last_slot;

  `TFD_ASSERT_IMP(a_last_is_final_slot, clk_i, rst_ni, m_valid_q && m_res_q.last_slot,
                  m_res_q.slot_index == tfd_pkg::LastSlot)
  `TFD_ASSERT_IMP(a_result_from_request, clk_i, rst_ni, $rose(m_valid_q), $past(s_accept))
  `TFD_ASSERT_IMP(a_result_held_when_stalled, clk_i, rst_ni, m_valid_q && !$past(s_accept),
                  $past(m_valid_q && !m_axis_tready_i))

endmodule

/* tb/tb.sv */
// Self-checking testbench for the touch frame deframer, with its own model of the deframer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfd_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int RandomBytes = 550;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [87:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  touch_frame_deframer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [PosW-1:0] at_byte = '0;
  logic            hdr_good = 1'b0;
  logic            seq_known = 1'b0;
  logic [15:0]     newest_seq = '0;
  logic [15:0]     cap_width = '0;
  logic [15:0]     cap_height = '0;
  logic [15:0]     cap_x = '0;
  logic [7:0]      pend_lo = '0;

  result_t    expected_touches[$];
  logic [7:0] frame_bytes[$];
  int         touch_errors = 0;
  int         bytes_sent = 0;
  bit         src_steady = 1'b0;
  bit         sink_steady = 1'b0;
  int         sink_hold = 0;

  function automatic void deframe_byte(input logic [7:0] b, input logic fresh);
    logic [15:0]     word;
    logic [15:0]     age;
    logic [PosW-1:0] rel;
    result_t         r;
    if (fresh) begin
      seq_known = 1'b0;
      newest_seq = '0;
      at_byte = '0;
    end
    if (int'(at_byte) >= FrameBytes) at_byte = '0;
    word = {b, pend_lo};
    case (at_byte)
      PosMagicR: hdr_good = (b == MagicR);
      PosMagicT: hdr_good = hdr_good && (b == MagicT);
      PosVersion: hdr_good = hdr_good && (b == Version);
      PosSpare: ;
      PosSeqLo, PosWidthLo, PosHeightLo: pend_lo = b;
      PosSeqHi: begin
        age = word - newest_seq;
        if (hdr_good && (!seq_known || (age != 16'h0000 && age < 16'h8000))) begin
          seq_known = 1'b1;
          newest_seq = word;
        end else begin
          hdr_good = 1'b0;
        end
      end
      PosWidthHi: cap_width = word;
      PosHeightHi: cap_height = word;
      default: begin
        rel = at_byte - PosHeader;
        case (rel[1:0])
          LaneXLo, LaneYLo: pend_lo = b;
          LaneXHi: cap_x = word;
          LaneYHi: begin
            if (hdr_good) begin
              r.frame_seq = newest_seq;
              r.frame_width = cap_width;
              r.frame_height = cap_height;
              r.slot_index = SlotW'(rel >> 2);
              r.touch_x = cap_x;
              r.touch_y = word;
              r.last_slot = (r.slot_index == LastSlot);
              expected_touches.push_back(r);
            end
          end
          default: ;
        endcase
      end
    endcase
    at_byte = (int'(at_byte) + 1 >= FrameBytes) ? '0 : at_byte + 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fresh);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tuser_i <= fresh;
    do @(posedge clk_i); while (!s_axis_tready_o);
    deframe_byte(b, fresh);
    bytes_sent++;
  endtask

  function automatic logic [15:0] draw_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] seq_step(input bit stale);
    if (stale) begin
      case ($urandom_range(0, 2))
        0: return 16'h0000;
        1: return 16'h8000;
        default: return 16'($urandom_range(16'h8000, 16'hFFFF));
      endcase
    end
    case ($urandom_range(0, 5))
      0: return 16'h0001;
      1: return 16'h7FFF;
      default: return 16'($urandom_range(1, 16'h7FFF));
    endcase
  endfunction

  task automatic build_frame(input logic [7:0] r, input logic [7:0] t, input logic [7:0] ver,
                             input logic [15:0] seq, input logic [15:0] w,
                             input logic [15:0] h);
    logic [15:0] x;
    logic [15:0] y;
    frame_bytes = {r, t, ver, 8'($urandom), seq[7:0], seq[15:8], w[7:0], w[15:8],
                   h[7:0], h[15:8]};
    for (int s = 0; s < SlotCount; s++) begin
      x = draw_coord();
      y = draw_coord();
      frame_bytes.push_back(x[7:0]);
      frame_bytes.push_back(x[15:8]);
      frame_bytes.push_back(y[7:0]);
      frame_bytes.push_back(y[15:8]);
    end
  endtask

  task automatic set_slot(input int s, input logic [15:0] x, input logic [15:0] y);
    frame_bytes[HeaderBytes + 4 * s]     = x[7:0];
    frame_bytes[HeaderBytes + 4 * s + 1] = x[15:8];
    frame_bytes[HeaderBytes + 4 * s + 2] = y[7:0];
    frame_bytes[HeaderBytes + 4 * s + 3] = y[15:8];
  endtask

  task automatic send_frame(input logic fresh, input int cut);
    for (int i = 0; i < cut; i++) send_byte(frame_bytes[i], fresh && (i == 0));
  endtask

  task automatic check_touch();
    result_t    got;
    result_t    want;
    logic [3:0] pad;
    got.frame_seq = m_axis_tdata_o[15:0];
    got.frame_width = m_axis_tdata_o[31:16];
    got.frame_height = m_axis_tdata_o[47:32];
    got.slot_index = m_axis_tdata_o[51:48];
    got.touch_x = m_axis_tdata_o[67:52];
    got.touch_y = m_axis_tdata_o[83:68];
    got.last_slot = m_axis_tlast_o;
    pad = m_axis_tdata_o[87:84];
    if (expected_touches.size() == 0) begin
      touch_errors++;
      if (touch_errors <= 10)
        $display("unexpected touch: seq %h slot %0d x %0d y %0d", got.frame_seq,
                 got.slot_index, got.touch_x, got.touch_y);
    end else begin
      want = expected_touches.pop_front();
      if (got !== want || pad !== 4'h0) begin
        touch_errors++;
        if (touch_errors <= 10) begin
          $display("touch mismatch, expected: seq %h w %h h %h slot %0d x %0d y %0d last %b",
                   want.frame_seq, want.frame_width, want.frame_height, want.slot_index,
                   want.touch_x, want.touch_y, want.last_slot);
          $display("  actual: seq %h w %h h %h slot %0d x %0d y %0d last %b pad %h",
                   got.frame_seq, got.frame_width, got.frame_height, got.slot_index,
                   got.touch_x, got.touch_y, got.last_slot, pad);
        end
      end
    end
  endtask

  task automatic test_extremes();
    build_frame(MagicR, MagicT, Version, 16'h0000, 16'hFFFF, 16'h0000);
    frame_bytes[3] = 8'hFF;
    set_slot(0, 16'h8000, 16'h7FFF);
    set_slot(1, 16'h7FFF, 16'h8000);
    set_slot(2, 16'h0000, 16'hFFFF);
    set_slot(SlotCount - 1, 16'hFFFF, 16'h0000);
    send_frame(1'b1, FrameBytes);
    build_frame(MagicR, MagicT, Version, 16'hFFFF, 16'h0000, 16'hFFFF);
    frame_bytes[3] = 8'h00;
    send_frame(1'b1, FrameBytes);
  endtask

  task automatic test_sequence();
    logic [15:0] seqs[8];
    seqs = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFF0, 16'h0005};
    for (int i = 0; i < 8; i++) begin
      build_frame(MagicR, MagicT, Version, seqs[i], 16'($urandom), 16'($urandom));
      send_frame(i == 0, FrameBytes);
    end
  endtask

  task automatic test_bad_header();
    build_frame(8'h72, MagicT, Version, newest_seq + 16'h0001, 16'h1234, 16'h5678);
    send_frame(1'b0, FrameBytes);
    build_frame(MagicR, 8'h52, Version, newest_seq + 16'h0001, 16'h1234, 16'h5678);
    send_frame(1'b0, FrameBytes);
    build_frame(MagicR, MagicT, 8'h00, newest_seq + 16'h0001, 16'h1234, 16'h5678);
    send_frame(1'b0, FrameBytes);
    build_frame(MagicR, MagicT, 8'h02, newest_seq + 16'h0001, 16'h1234, 16'h5678);
    send_frame(1'b0, FrameBytes);
    build_frame(MagicR, MagicT, Version, newest_seq + 16'h0001, 16'h4321, 16'h8765);
    send_frame(1'b0, FrameBytes);
  endtask

  task automatic test_new_connection();
    build_frame(MagicR, MagicT, Version, newest_seq + 16'd100, 16'($urandom), 16'($urandom));
    send_frame(1'b0, 23);
    build_frame(MagicR, MagicT, Version, newest_seq, 16'($urandom), 16'($urandom));
    send_frame(1'b1, FrameBytes);
    build_frame(8'h00, MagicT, Version, newest_seq + 16'd1, 16'($urandom), 16'($urandom));
    send_frame(1'b0, 30);
    build_frame(MagicR, MagicT, Version, newest_seq - 16'd5, 16'($urandom), 16'($urandom));
    send_frame(1'b1, FrameBytes);
  endtask

  task automatic test_back_to_back();
    src_steady = 1'b1;
    sink_steady = 1'b1;
    repeat (2) begin
      build_frame(MagicR, MagicT, Version, newest_seq + seq_step(1'b0), 16'($urandom),
                  16'($urandom));
      send_frame(1'b0, FrameBytes);
    end
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_pressure();
    sink_hold = 300;
    src_steady = 1'b1;
    repeat (2) begin
      build_frame(MagicR, MagicT, Version, newest_seq + seq_step(1'b0), 16'($urandom),
                  16'($urandom));
      send_frame(1'b0, FrameBytes);
    end
    src_steady = 1'b0;
  endtask

  task automatic test_random();
    int          kind;
    int          cut;
    int          start;
    logic        fresh;
    logic        need_fresh;
    logic [15:0] seq;
    logic [7:0]  hdr[3];
    start = bytes_sent;
    need_fresh = 1'b1;
    while (bytes_sent - start < RandomBytes) begin
      kind = $urandom_range(0, 19);
      fresh = need_fresh || ($urandom_range(0, 15) == 0);
      need_fresh = 1'b0;
      src_steady = ($urandom_range(0, 5) == 0);
      sink_steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 40) == 0) sink_hold = $urandom_range(40, 200);
      hdr = '{MagicR, MagicT, Version};
      cut = FrameBytes;
      seq = newest_seq + seq_step(kind == 1 || kind == 2);
      case (kind)
        0: hdr[$urandom_range(0, 2)] = 8'($urandom);
        3: begin
          cut = $urandom_range(1, FrameBytes - 1);
          need_fresh = 1'b1;
        end
        4: begin
          repeat ($urandom_range(1, 20)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
          need_fresh = 1'b1;
        end
        default: ;
      endcase
      if (kind != 4) begin
        build_frame(hdr[0], hdr[1], hdr[2], seq, 16'($urandom), 16'($urandom));
        send_frame(fresh, cut);
      end
    end
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin : sink
    int stall;
    @(posedge rst_ni);
    m_axis_tready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      check_touch();
      stall = sink_steady ? 0 : $urandom_range(0, 16);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_sequence();
    test_bad_header();
    test_new_connection();
    test_back_to_back();
    test_pressure();
    test_random();
    s_axis_tvalid_i <= 1'b0;
    while (expected_touches.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (touch_errors == 0 && expected_touches.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
